// ===== src/stm_pkg.sv =====
`timescale 1ns / 1ps
package stm_pkg;

    localparam int MAX_WORDS_DEF = 256;
    localparam int MAX_CHARS_DEF = 9;

    localparam int CH_W       = 8;
    localparam int IDX_OUT_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - 1 - IDX_OUT_W;

    // kind of input item, carried on tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_CHR_RD,
        ST_CHR_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic next_entry;
        logic chr_start;
        logic chr_next;
        logic set_hit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic query_end;
        logic query_over;
        logic idx_end;
        logic len_zero;
        logic len_eq;
        logic chr_eq;
        logic chr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/stm_ram.sv =====
`timescale 1ns / 1ps
module stm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/stm_ctrl.sv =====
`timescale 1ns / 1ps
module stm_ctrl import stm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.query_end) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_LEN_RD;
                    end
                end
            end
            ST_LEN_RD: begin
                if (i_sts.query_over || i_sts.idx_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_LEN_CHK;
                end
            end
            ST_LEN_CHK: begin
                // an empty entry closes the searched part of the table
                if (i_sts.len_zero) begin
                    n_state = ST_DONE;
                end else if (!i_sts.len_eq) begin
                    o_cmd.next_entry = 1'b1;
                    n_state = ST_LEN_RD;
                end else begin
                    o_cmd.chr_start = 1'b1;
                    n_state = ST_CHR_RD;
                end
            end
            ST_CHR_RD: begin
                n_state = ST_CHR_CHK;
            end
            ST_CHR_CHK: begin
                if (!i_sts.chr_eq) begin
                    o_cmd.next_entry = 1'b1;
                    n_state = ST_LEN_RD;
                end else if (i_sts.chr_last) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.chr_next = 1'b1;
                    n_state = ST_CHR_RD;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/stm_dpath.sv =====
`timescale 1ns / 1ps
module stm_dpath import stm_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_func,
    input  logic [CH_W-1:0]       i_ch,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int WC_W  = $clog2(MAX_WORDS + 1);
    localparam int IDX_W = $clog2(MAX_WORDS);
    localparam int LEN_W = $clog2(MAX_CHARS + 2);
    localparam int QI_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int DEPTH = MAX_WORDS * MAX_CHARS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [LEN_W-1:0] LEN_LIM  = LEN_W'(MAX_CHARS);
    localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_CHARS + 1);
    localparam logic [AW-1:0]    STRIDE   = AW'(MAX_CHARS);
    localparam logic [WC_W-1:0]  WC_FULL  = WC_W'(MAX_WORDS);

    // load side
    logic [WC_W-1:0]  r_wc,    n_wc;
    logic [LEN_W-1:0] r_lpos,  n_lpos;
    logic             r_lover, n_lover;
    logic             r_lend,  n_lend;
    logic [AW-1:0]    r_lbase, n_lbase;
    // query side
    logic [CH_W-1:0]  r_qbuf [MAX_CHARS];
    logic [LEN_W-1:0] r_qlen,  n_qlen;
    logic             r_qover, n_qover;
    logic             r_qend,  n_qend;
    // scan
    logic [WC_W-1:0]  r_idx;
    logic [AW-1:0]    r_sbase;
    logic [LEN_W-1:0] r_k;
    logic             r_hit;
    // result
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic             w_take_load;
    logic             w_take_query;
    logic             w_chr_we;
    logic [AW-1:0]    w_chr_waddr;
    logic             w_len_we;
    logic [LEN_W-1:0] w_len_wdata;
    logic             w_q_we;
    logic [AW-1:0]    w_chr_raddr;
    logic [CH_W-1:0]  w_chr_rdata;
    logic [LEN_W-1:0] w_len_rdata;
    logic [IDX_W+IDX_OUT_W-1:0] w_idx_ext;
    logic [IDX_OUT_W-1:0]       w_where;

    assign w_take_load  = i_cmd.take && (i_func == FUNC_LOAD) && (r_wc != WC_FULL);
    assign w_take_query = i_cmd.take && (i_func == FUNC_QUERY);

    assign w_chr_we    = w_take_load && !r_lend && (i_ch != '0) && (r_lpos < LEN_LIM);
    assign w_chr_waddr = r_lbase + AW'(r_lpos);
    assign w_len_we    = w_take_load && i_last;
    assign w_q_we      = w_take_query && !r_qend && (i_ch != '0) && (r_qlen < LEN_LIM);

    always_comb begin
        n_lpos  = r_lpos;
        n_lover = r_lover;
        n_lend  = r_lend;
        n_wc    = r_wc;
        n_lbase = r_lbase;
        if (w_take_load && !r_lend) begin
            if (i_ch == '0) begin
                n_lend = 1'b1;
            end else if (r_lpos < LEN_LIM) begin
                n_lpos = r_lpos + LEN_W'(1);
            end else begin
                n_lover = 1'b1;
            end
        end
        w_len_wdata = n_lover ? LEN_OVER : n_lpos;
        // close the entry
        if (w_len_we) begin
            n_wc    = r_wc + WC_W'(1);
            n_lbase = r_lbase + STRIDE;
            n_lpos  = '0;
            n_lover = 1'b0;
            n_lend  = 1'b0;
        end
    end

    always_comb begin
        n_qlen  = r_qlen;
        n_qover = r_qover;
        n_qend  = r_qend;
        if (w_take_query && !r_qend) begin
            if (i_ch == '0) begin
                n_qend = 1'b1;
            end else if (r_qlen < LEN_LIM) begin
                n_qlen = r_qlen + LEN_W'(1);
            end else begin
                n_qover = 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            n_qlen  = '0;
            n_qover = 1'b0;
            n_qend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc    <= '0;
            r_lpos  <= '0;
            r_lover <= 1'b0;
            r_lend  <= 1'b0;
            r_lbase <= '0;
            r_qlen  <= '0;
            r_qover <= 1'b0;
            r_qend  <= 1'b0;
        end else begin
            r_wc    <= n_wc;
            r_lpos  <= n_lpos;
            r_lover <= n_lover;
            r_lend  <= n_lend;
            r_lbase <= n_lbase;
            r_qlen  <= n_qlen;
            r_qover <= n_qover;
            r_qend  <= n_qend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_qbuf[r_qlen[QI_W-1:0]] <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_sbase <= '0;
            r_k     <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_sbase <= '0;
                r_hit   <= 1'b0;
            end else if (i_cmd.next_entry) begin
                r_idx   <= r_idx + WC_W'(1);
                r_sbase <= r_sbase + STRIDE;
            end
            if (i_cmd.chr_start) begin
                r_k <= '0;
            end else if (i_cmd.chr_next) begin
                r_k <= r_k + LEN_W'(1);
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign w_chr_raddr = r_sbase + AW'(r_k);

    stm_ram #(
        .WIDTH(CH_W),
        .DEPTH(DEPTH)
    ) u_chr_ram (
        .i_clk  (i_clk),
        .i_we   (w_chr_we),
        .i_waddr(w_chr_waddr),
        .i_wdata(i_ch),
        .i_raddr(w_chr_raddr),
        .o_rdata(w_chr_rdata)
    );

    stm_ram #(
        .WIDTH(LEN_W),
        .DEPTH(MAX_WORDS)
    ) u_len_ram (
        .i_clk  (i_clk),
        .i_we   (w_len_we),
        .i_waddr(r_wc[IDX_W-1:0]),
        .i_wdata(w_len_wdata),
        .i_raddr(r_idx[IDX_W-1:0]),
        .o_rdata(w_len_rdata)
    );

    assign w_idx_ext = (IDX_W + IDX_OUT_W)'(r_idx[IDX_W-1:0]);
    assign w_where   = r_hit ? w_idx_ext[IDX_OUT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, w_where, r_hit};
        end
    end

    assign o_sts.query_end  = (i_func == FUNC_QUERY) && i_last;
    assign o_sts.query_over = r_qover;
    assign o_sts.idx_end    = (r_idx == r_wc);
    assign o_sts.len_zero   = (w_len_rdata == '0);
    assign o_sts.len_eq     = (w_len_rdata == r_qlen);
    assign o_sts.chr_eq     = (w_chr_rdata == r_qbuf[r_k[QI_W-1:0]]);
    assign o_sts.chr_last   = ((r_k + LEN_W'(1)) == r_qlen);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/stopword_table_matcher_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata: ch[7:0]; tuser: func; tlast: last
// m (out)   out  o_m_tvalid/i_m_tready  tdata: is_stop[0], match_index[8:1], 0[15:9]
//
// Load items and query items that are not the last of a word leave the controller idle.
// A query's last item starts a scan of the table from entry 0: each entry gets a
// length read and a length check (ST_LEN_RD, ST_LEN_CHK), each compared character a
// read and a check (ST_CHR_RD, ST_CHR_CHK), and ST_DONE loads the result; ST_LEN_RD
// goes straight to ST_DONE when the scan runs past the last entry or the query is
// overlong. The read states are there for the registered memory reads.
// o_s_tready stays low through a scan and while a finished result cannot yet
// move into the output register. Reset (synchronous, active low) empties the table.
module stopword_table_matcher_unit import stm_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [CH_W-1:0]       i_s_tdata,  // [7:0] ch
    input  logic                  i_s_tuser,  // [0] func
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // [0] is_stop, [8:1] match_index
);

    t_cmd w_cmd;
    t_sts w_sts;

    stm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid),
        .o_ready(o_s_tready),
        .o_cmd  (w_cmd),
        .i_sts  (w_sts)
    );

    stm_dpath #(
        .MAX_WORDS(MAX_WORDS),
        .MAX_CHARS(MAX_CHARS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_func     (i_s_tuser),
        .i_ch       (i_s_tdata),
        .i_last     (i_s_tlast),
        .o_out_valid(o_m_tvalid),
        .i_out_ready(i_m_tready),
        .o_out_data (o_m_tdata)
    );

endmodule

// ===== src/stm_checker.sv =====
`timescale 1ns / 1ps
module stm_checker import stm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [CH_W-1:0]       i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a miss carries index zero and the pad bits stay clear
    a_miss_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_DATA_W-1:9] == '0) &&
                       (o_m_tdata[0] || (o_m_tdata[8:1] == '0)))
        else $error("bad result word");

    // the end of a query word starts a scan that blocks the input
    a_scan_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_QUERY) && i_s_tlast
        |=> !o_s_tready)
        else $error("input taken during scan");

    // a new result only comes out of a scan
    a_rise_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result without scan");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind stopword_table_matcher_unit stm_checker u_stm_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import stm_pkg::*;

    localparam int TARGET_ITEMS   = 1950;
    localparam int VOCAB_MAX      = 512;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int EMPTY_AT       = 250;

    typedef struct packed {
        logic       hit;
        logic [7:0] idx;
    } t_lookup;

    class stopword_scoreboard;
        logic [7:0] chars [MAX_WORDS_DEF][MAX_CHARS_DEF];
        logic [3:0] ent_len [MAX_WORDS_DEF];
        int         word_count = 0;
        int         load_pos   = 0;
        bit         load_over  = 0;
        bit         load_done  = 0;
        logic [7:0] qbuf [MAX_CHARS_DEF];
        int         qlen       = 0;
        bit         q_over     = 0;
        bit         q_done     = 0;
        t_lookup    lookup_q[$];
        int         errors     = 0;

        // first searched entry equal to the query word
        function t_lookup scan_table();
            t_lookup r;
            bit      same;
            r = '0;
            if (q_over)
                return r;
            for (int i = 0; i < word_count; i++) begin
                if (ent_len[i] == 0)
                    break;
                if (ent_len[i] == qlen) begin
                    same = 1;
                    for (int k = 0; k < qlen; k++)
                        if (chars[i][k] != qbuf[k])
                            same = 0;
                    if (same) begin
                        r.hit = 1'b1;
                        r.idx = 8'(i);
                        return r;
                    end
                end
            end
            return r;
        endfunction

        function void note_item(logic f, logic [7:0] c, logic l);
            if (f == FUNC_LOAD) begin
                // drop loads once the table is full
                if (word_count >= MAX_WORDS_DEF)
                    return;
                if (!load_done) begin
                    if (c == 8'd0)
                        load_done = 1;
                    else if (load_pos < MAX_CHARS_DEF) begin
                        chars[word_count][load_pos] = c;
                        load_pos++;
                    end else
                        load_over = 1;
                end
                if (l) begin
                    ent_len[word_count] = load_over ? 4'(MAX_CHARS_DEF + 1) : 4'(load_pos);
                    word_count++;
                    load_pos  = 0;
                    load_over = 0;
                    load_done = 0;
                end
                return;
            end
            if (!q_done) begin
                if (c == 8'd0)
                    q_done = 1;
                else if (qlen < MAX_CHARS_DEF) begin
                    qbuf[qlen] = c;
                    qlen++;
                end else
                    q_over = 1;
            end
            if (!l)
                return;
            lookup_q.push_back(scan_table());
            qlen   = 0;
            q_over = 0;
            q_done = 0;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_lookup e;
            if (lookup_q.size() == 0) begin
                $error("is_stop: no result expected, actual %0d (match_index %0d)",
                       d[0], d[8:1]);
                errors++;
                return;
            end
            e = lookup_q.pop_front();
            if (d[0] !== e.hit) begin
                $error("is_stop: expected %0d, actual %0d", e.hit, d[0]);
                errors++;
            end
            if (d[8:1] !== e.idx) begin
                $error("match_index: expected %0d, actual %0d", e.idx, d[8:1]);
                errors++;
            end
            if (d[OUT_DATA_W-1:9] !== '0) begin
                $error("pad: expected 0, actual %0h", d[OUT_DATA_W-1:9]);
                errors++;
            end
        endfunction

        function int pending();
            return lookup_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [CH_W-1:0]       i_s_tdata  = '0;   // [7:0] ch
    logic                  i_s_tuser  = 1'b0; // [0] func
    logic                  i_s_tlast  = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [0] is_stop, [8:1] match_index

    stopword_scoreboard board = new();

    int         n_items    = 0;
    int         n_loaded   = 0;
    int         stall_cnt  = 0;
    bit         calm       = 0;
    bit         hold_rx    = 0;
    logic [7:0] word[$];
    logic [7:0] vocab_ch [VOCAB_MAX][16];
    int         vocab_len [VOCAB_MAX];
    int         vocab_n    = 0;

    stopword_table_matcher_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                board.note_item(i_s_tuser, i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                board.check_result(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cnt <= 0;
        else if (stall_cnt == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            stall_cnt <= stall_cnt + 1;
    end

    // receiver: random backpressure, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 0;
            end else
                i_m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_item(input logic f, input logic [7:0] c, input logic l);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 7)
                gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= f;
        i_s_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_word(input logic f);
        for (int k = 0; k < word.size(); k++)
            send_item(f, word[k], k == word.size() - 1);
    endtask

    // hold the sender until every lookup has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.pending() != 0);
    endtask

    task automatic make_fresh();
        int  r;
        int  n;
        bit  narrow;
        r      = $urandom_range(99);
        n      = (r < 55) ? $urandom_range(4, 1) :
                 (r < 90) ? $urandom_range(MAX_CHARS_DEF, 5) :
                            $urandom_range(MAX_CHARS_DEF + 3, MAX_CHARS_DEF + 1);
        // a narrow alphabet gives shared prefixes and duplicate entries
        narrow = $urandom_range(1);
        word.delete();
        for (int k = 0; k < n; k++)
            word.push_back(narrow ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255, 1)));
        if (n > 1 && $urandom_range(99) < 6)
            word[$urandom_range(n - 1, 1)] = 8'd0;
    endtask

    task automatic pick_vocab();
        int v;
        v = $urandom_range(vocab_n - 1);
        word.delete();
        for (int k = 0; k < vocab_len[v]; k++)
            word.push_back(vocab_ch[v][k]);
    endtask

    task automatic load_word();
        if (vocab_n > 0 && $urandom_range(99) < 12)
            pick_vocab();
        else
            make_fresh();
        if (vocab_n < VOCAB_MAX) begin
            for (int k = 0; k < word.size(); k++)
                vocab_ch[vocab_n][k] = word[k];
            vocab_len[vocab_n] = word.size();
            vocab_n++;
        end
        send_word(FUNC_LOAD);
        n_loaded++;
    endtask

    task automatic query_word();
        int r;
        r = $urandom_range(99);
        if (vocab_n == 0 || r >= 85)
            make_fresh();
        else begin
            pick_vocab();
            if (r >= 55 && r < 65)
                word[$urandom_range(word.size() - 1)] = 8'($urandom_range(255, 1));
            else if (r >= 65 && r < 75) begin
                if (word.size() > 1)
                    void'(word.pop_back());
                else
                    word.push_back(8'($urandom_range(255, 1)));
            end else if (r >= 75) begin
                // terminate early; the trailing bytes must be ignored
                word.push_back(8'd0);
                repeat ($urandom_range(2, 1)) word.push_back(8'($urandom));
            end
        end
        send_word(FUNC_QUERY);
    endtask

    task automatic directed();
        word = '{8'hFF};
        send_word(FUNC_LOAD);
        word = '{8'h01, 8'h80, 8'h7F};
        send_word(FUNC_LOAD);
        word = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A};
        send_word(FUNC_LOAD);
        word = '{8'h61, 8'h00, 8'h7A};
        send_word(FUNC_LOAD);
        n_loaded += 4;
        word = '{8'hFF};
        send_word(FUNC_QUERY);
        word = '{8'h01, 8'h80, 8'h7F};
        send_word(FUNC_QUERY);
        word = '{8'h61, 8'h00, 8'h71};
        send_word(FUNC_QUERY);
        word = '{8'h00};
        send_word(FUNC_QUERY);
        word = '{8'h01, 8'h80};
        send_word(FUNC_QUERY);
    endtask

    initial begin
        bit held;
        bit empty_done;
        held       = 0;
        empty_done = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        drain();
        while (n_items < TARGET_ITEMS) begin
            calm = (n_items >= 1000 && n_items < 1300);
            if (!held && n_items >= 700) begin
                // stall the output so the block backs up into its input
                held    = 1;
                hold_rx = 1;
                repeat (6) query_word();
                drain();
            end else if (!empty_done && n_loaded == EMPTY_AT) begin
                // an empty entry cuts off every entry loaded after it
                empty_done = 1;
                word = '{8'h00, 8'($urandom), 8'($urandom)};
                send_word(FUNC_LOAD);
                n_loaded++;
            end else if ($urandom_range(99) < (n_loaded < MAX_WORDS_DEF ? 70 : 12))
                load_word();
            else
                query_word();
        end
        calm = 0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/stm_pkg.sv
src/stm_ram.sv
src/stm_ctrl.sv
src/stm_dpath.sv
src/stopword_table_matcher_unit.sv
src/stm_checker.sv
tb/sv/tb_top.sv
